FILE: rtl/pba_pkg.sv
// Shared types, codes and helpers of the page bitmap allocator.
`timescale 1ns / 1ps
package pba_pkg;

    localparam int MAX_PAGES_DEF = 4096;
    localparam int WORD_BITS     = 64;
    localparam int BASE_W        = 40;
    localparam int RUN_W         = 13;
    localparam int MAP_RESET     = 4096;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_DOUBLE  = 3'd2,
        ST_TAKEN   = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MARK_RD,
        S_MARK_EV,
        S_DONE
    } state_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [5:0] low_bit(input logic [WORD_BITS-1:0] v);
        logic [5:0] r;
        r = 6'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator.
`timescale 1ns / 1ps
// First-fit page allocator over a bitmap of MAX_PAGES bits (1 = used) held in
// a memory of 64-bit words. After reset the block writes every word to all
// ones and takes no request meanwhile. One request is handled at a time:
// range checks, then a read and an evaluation for every bitmap word visited,
// with a write back when marking. Free and reserve visit the words their run
// covers; allocate visits the words from each candidate start up to the first
// used page, one alignment step per conflict, then the words of the chosen run
// again to mark them. Every used page the search runs into sends it back
// through align, read and evaluate. The next request can be taken while the
// previous result still waits at the output.
module page_bitmap_allocator_unit #(
    parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [pba_pkg::BASE_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [pba_pkg::BASE_W-1:0] first_page,
    input  logic [pba_pkg::RUN_W-1:0]  run_pages,
    input  logic [3:0]                 align_log2,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [pba_pkg::BASE_W-1:0] found_page
);
    import pba_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + 63) / 64;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    pba_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .MAP_WORDS (MAP_WORDS),
        .AW        (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .first_page (first_page),
        .run_pages  (run_pages),
        .align_log2 (align_log2),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .found_page (found_page),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    pba_bitmap_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/pba_bitmap_ram.sv
// Bitmap word memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pba_bitmap_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [pba_pkg::WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [pba_pkg::WORD_BITS-1:0] rdata
);
    import pba_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pba_ctrl.sv
// Request sequencer: range checks, first-fit search and run marking over bitmap words.
`timescale 1ns / 1ps
module pba_ctrl #(
    parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF,
    parameter int MAP_WORDS = (MAX_PAGES + 63) / 64,
    parameter int AW        = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [pba_pkg::BASE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [pba_pkg::BASE_W-1:0]    first_page,
    input  logic [pba_pkg::RUN_W-1:0]     run_pages,
    input  logic [3:0]                    align_log2,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [pba_pkg::BASE_W-1:0]    found_page,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [pba_pkg::WORD_BITS-1:0] mem_wdata,
    output logic [AW-1:0]                 mem_raddr,
    input  logic [pba_pkg::WORD_BITS-1:0] mem_rdata
);
    import pba_pkg::*;

    localparam int PW = $clog2(MAX_PAGES + 1);
    localparam int IW = ((PW > 16) ? PW : 16) + 2;
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    state_t state_reg, state_next;

    logic [BASE_W-1:0] base_reg, base_next;
    logic [RUN_W-1:0]  map_reg, map_next;
    logic [1:0]        op_reg, op_next;
    logic [BASE_W-1:0] first_reg, first_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic [3:0]        lg_reg, lg_next;
    logic [IW-1:0]     cand_reg, cand_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     end_reg, end_next;
    logic              set_reg, set_next;
    status_t           res_st_reg, res_st_next;
    logic [BASE_W-1:0] res_pg_reg, res_pg_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [BASE_W-1:0] found_reg, found_next;

    logic [IW-1:0]        managed;
    logic [IW-1:0]        run_x;
    logic [BASE_W-1:0]    idx;
    logic [15:0]          al_mask;
    logic [15:0]          al_low;
    logic [IW-1:0]        al_pos;
    logic [IW-1:0]        al_end;
    logic [IW-1:0]        end_m1;
    logic                 last_word;
    logic [5:0]           hi;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] hits;
    logic [WORD_BITS-1:0] conf;
    logic [WORD_BITS-1:0] change;
    logic [5:0]           hit_b;
    logic [5:0]           conf_b;
    logic                 out_free;

    assign managed = (IW'(map_reg) > IW'(MAX_PAGES)) ? IW'(MAX_PAGES) : IW'(map_reg);
    assign run_x   = IW'(run_reg);
    assign idx     = first_reg - base_reg;

    // next index at or after pos whose absolute frame is aligned
    assign al_mask = (16'd1 << lg_reg) - 16'd1;
    assign al_low  = (base_reg[15:0] + pos_reg[15:0]) & al_mask;
    assign al_pos  = pos_reg + IW'((16'd0 - al_low) & al_mask);
    assign al_end  = al_pos + run_x;

    // bits of the current word that lie inside [pos, end)
    assign end_m1     = end_reg - IW'(1);
    assign last_word  = (end_m1[IW-1:6] == pos_reg[IW-1:6]);
    assign hi         = last_word ? end_m1[5:0] : 6'd63;
    assign range_mask = (ONES << pos_reg[5:0]) & (ONES >> (6'd63 - hi));
    assign hits       = mem_rdata & range_mask;
    assign conf       = (set_reg ? mem_rdata : ~mem_rdata) & range_mask;
    assign hit_b      = low_bit(hits);
    assign conf_b     = low_bit(conf);
    assign change     = (|conf) ? (range_mask & ~(ONES << conf_b)) : range_mask;
    assign out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= '0;
            map_reg       <= RUN_W'(MAP_RESET);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            map_reg       <= map_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        first_reg  <= first_next;
        run_reg    <= run_next;
        lg_reg     <= lg_next;
        cand_reg   <= cand_next;
        pos_reg    <= pos_next;
        end_reg    <= end_next;
        set_reg    <= set_next;
        res_st_reg <= res_st_next;
        res_pg_reg <= res_pg_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (run_reg != '0 && run_x <= managed)
                        begin
                            state_next = S_ALIGN;
                        end
                    end
                    OP_FREE, OP_RESERVE:
                    begin
                        if (run_reg != '0 && first_reg >= base_reg &&
                            idx <= BASE_W'(managed) &&
                            run_x <= managed - IW'(idx))
                        begin
                            state_next = S_MARK_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALIGN:
            begin
                state_next = (al_end > managed) ? S_DONE : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (|hits)
                begin
                    state_next = S_ALIGN;
                end
                else if (last_word)
                begin
                    state_next = S_MARK_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MARK_RD:
            begin
                state_next = S_MARK_EV;
            end
            S_MARK_EV:
            begin
                state_next = ((|conf) || last_word) ? S_DONE : S_MARK_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        base_next      = base_reg;
        map_next       = map_reg;
        op_next        = op_reg;
        first_next     = first_reg;
        run_next       = run_reg;
        lg_next        = lg_reg;
        cand_next      = cand_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        set_next       = set_reg;
        res_st_next    = res_st_reg;
        res_pg_next    = res_pg_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        found_next     = found_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[AW+5:6];
        mem_wdata      = mem_rdata;
        in_stall       = (state_reg != S_IDLE);

        if (cfg_valid)
        begin
            if (cfg_index == 2'd0)
            begin
                base_next = cfg_data;
            end
            else if (cfg_index == 2'd1)
            begin
                map_next = cfg_data[RUN_W-1:0];
            end
        end

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = ONES;
                clr_next  = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                op_next    = op;
                first_next = first_page;
                run_next   = run_pages;
                lg_next    = align_log2;
            end
            S_CHECK:
            begin
                res_pg_next = '0;
                res_st_next = ST_RANGE;
                pos_next    = IW'(idx);
                end_next    = IW'(idx) + run_x;
                set_next    = (op_reg == OP_RESERVE);
                if (op_reg == OP_ALLOC)
                begin
                    pos_next = '0;
                    if (run_reg != '0)
                    begin
                        res_st_next = ST_NOSPACE;
                    end
                end
            end
            S_ALIGN:
            begin
                cand_next = al_pos;
                pos_next  = al_pos;
                end_next  = al_end;
            end
            S_SCAN_EV:
            begin
                if (|hits)
                begin
                    pos_next = {pos_reg[IW-1:6], hit_b} + IW'(1);
                end
                else if (last_word)
                begin
                    pos_next = cand_reg;
                    set_next = 1'b1;
                end
                else
                begin
                    pos_next = {pos_reg[IW-1:6] + (IW-6)'(1), 6'd0};
                end
            end
            S_MARK_EV:
            begin
                mem_we    = 1'b1;
                mem_wdata = set_reg ? (mem_rdata | change) : (mem_rdata & ~change);
                pos_next  = {pos_reg[IW-1:6] + (IW-6)'(1), 6'd0};
                if (|conf)
                begin
                    res_st_next = set_reg ? ST_TAKEN : ST_DOUBLE;
                end
                else
                begin
                    res_st_next = ST_OK;
                    if (op_reg == OP_ALLOC)
                    begin
                        res_pg_next = base_reg + BASE_W'(cand_reg);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_st_reg;
                    found_next     = res_pg_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr  = pos_reg[AW+5:6];
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_page = found_reg;

endmodule

FILE: rtl/pba_checker.sv
// Port-level checks of the page bitmap allocator, bound to the top level.
`timescale 1ns / 1ps
module pba_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [2:0]                 status,
    input logic [pba_pkg::BASE_W-1:0] found_page
);
    import pba_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_page))
        else $error("result changed under stall");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_page == '0)
        else $error("page reported with a failing status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_RANGE)
        else $error("undefined status code");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);
